/* src/trld_pkg.sv */
// ----------------------------------------------------------------------------
// trld_pkg
// shared types and constants of the texture line run-length decoder
// ----------------------------------------------------------------------------
package trld_pkg;

    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 24;
    localparam int LINE_LEN_W       = 16;
    localparam int RUN_LEN_W        = 5;
    localparam int NPIX_W           = 6;
    localparam int POS_W            = 5;
    localparam int LINE_COUNT_W     = 11;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 24;
    localparam int HEADER_BYTES     = 4;
    localparam int HDR_CNT_W        = $clog2(HEADER_BYTES);
    localparam int RESULTS_PER_STEP = 31;

    localparam int MAX_LINES_DEF       = 1024;
    localparam int CMD_QUEUE_DEPTH_DEF = 4;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hE0;

    localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST = 11'd64;
    localparam logic                    BIG_SIZES_RST  = 1'b0;
    localparam logic [COUNT_W-1:0]      OUT_LIMIT_RST  = 24'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_COUNT     = 2'd0,
        CFG_BIG_LINE_SIZES = 2'd1,
        CFG_OUT_LIMIT      = 2'd2
    } trld_cfg_index_t;

    typedef struct packed {
        logic [LINE_COUNT_W-1:0] line_count;
        logic                    big_line_sizes;
        logic [COUNT_W-1:0]      out_limit;
    } trld_cfg_t;

    // results of one input byte: npix copies of value, then an optional status
    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic [NPIX_W-1:0]  npix;
        logic               err;
        logic               done;
        logic [COUNT_W-1:0] base;
    } trld_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  pixel;
        logic               pixel_valid;
        logic               run_last;
        logic               done_res;
        logic               error;
        logic [COUNT_W-1:0] out_count;
    } trld_result_t;

endpackage

/* src/trld_in_if.sv */
// ----------------------------------------------------------------------------
// trld_in_if
// compressed byte channel, one buffer byte per transfer
// ----------------------------------------------------------------------------
interface trld_in_if;
    import trld_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              first;

    modport source (output valid, output in_byte, output first, input ready);
    modport sink   (input valid, input in_byte, input first, output ready);
endinterface

/* src/trld_out_if.sv */
// ----------------------------------------------------------------------------
// trld_out_if
// expanded pixel channel, one result per transfer
// ----------------------------------------------------------------------------
interface trld_out_if;
    import trld_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  pixel;
    logic               pixel_valid;
    logic               run_last;
    logic               done_res;
    logic               error;
    logic [COUNT_W-1:0] out_count;

    modport source (output valid, output pixel, output pixel_valid, output run_last,
                    output done_res, output error, output out_count, input ready);
    modport sink   (input valid, input pixel, input pixel_valid, input run_last,
                    input done_res, input error, input out_count, output ready);
endinterface

/* src/trld_front.sv */
// ----------------------------------------------------------------------------
// trld_front
// parses header, line sizes and line codes; one command per input byte
// ----------------------------------------------------------------------------
module trld_front #(
    parameter int MAX_LINES = trld_pkg::MAX_LINES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    trld_in_if.sink             in_ch,
    input  trld_pkg::trld_cfg_t cfg,
    input  logic                queue_full,
    output logic                push,
    output trld_pkg::trld_cmd_t push_cmd
);
    import trld_pkg::*;

    localparam int LINE_CW = $clog2(MAX_LINES + 1);
    localparam int LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SIZES  = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_TAIL   = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'b001,
        ST_SEEK_ADDR = 3'b010,
        ST_SEEK_DATA = 3'b100
    } seek_state_t;

    phase_t                 phase_reg, phase_next, ph_cur;
    seek_state_t            state_reg, state_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next, hdr_cur;
    logic                   size_half_reg, size_half_next, size_half_cur;
    logic [BYTE_W-1:0]      size_low_reg, size_low_next;
    logic [LINE_CW-1:0]     line_idx_reg, line_idx_next, line_idx_cur;
    logic [LINE_LEN_W-1:0]  pos_reg, pos_next, pos_cur;
    logic [LINE_LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic [RUN_LEN_W-1:0]   pending_reg, pending_next, pending_cur;
    logic [COUNT_W-1:0]     emitted_reg, emitted_next, emitted_cur;
    logic [LINE_CW-1:0]     seek_idx_reg, seek_idx_next;
    logic                   seek_run_reg, seek_run_next;
    trld_cmd_t              cmd_reg, cmd_next;

    logic [LINE_LEN_W-1:0]  line_len_mem [MAX_LINES];
    logic [LINE_LEN_W-1:0]  rd_data_reg;
    logic                   mem_we, mem_re;
    logic [LINE_AW-1:0]     mem_waddr, mem_raddr;
    logic [LINE_LEN_W-1:0]  mem_wdata;

    logic [LINE_CW-1:0]     lines_total;
    logic                   accept;
    trld_cmd_t              step_cmd;
    logic                   start_seek, seek_run;
    logic [LINE_CW-1:0]     seek_start;
    logic                   is_run, lb, line_end, over, at_limit;
    logic [RUN_LEN_W-1:0]   run_len;
    logic [COUNT_W:0]       sum, sum_p1, limit_ext;

    always_comb
    begin
        if (32'(cfg.line_count) > 32'(MAX_LINES))
            lines_total = LINE_CW'(MAX_LINES);
        else
            lines_total = LINE_CW'(cfg.line_count);
    end

    assign in_ch.ready = (state_reg == ST_IDLE) && !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // restart clears the parse before this byte is taken
    assign ph_cur        = in_ch.first ? PH_HEADER : phase_reg;
    assign hdr_cur       = in_ch.first ? '0 : hdr_cnt_reg;
    assign size_half_cur = in_ch.first ? 1'b0 : size_half_reg;
    assign line_idx_cur  = in_ch.first ? '0 : line_idx_reg;
    assign pos_cur       = in_ch.first ? '0 : pos_reg;
    assign pending_cur   = in_ch.first ? '0 : pending_reg;
    assign emitted_cur   = in_ch.first ? '0 : emitted_reg;

    assign is_run    = (in_ch.in_byte & RUN_MARK) == RUN_MARK;
    assign run_len   = in_ch.in_byte[RUN_LEN_W-1:0];
    assign lb        = (pending_cur == '0) || (pos_cur == '0);
    assign line_end  = ({1'b0, pos_cur} + 17'd1) >= {1'b0, cur_len_reg};
    assign sum       = {1'b0, emitted_cur} + (COUNT_W+1)'(pending_cur);
    assign sum_p1    = {1'b0, emitted_cur} + (COUNT_W+1)'(pending_cur) + 25'd1;
    assign limit_ext = {1'b0, cfg.out_limit};
    assign over      = sum > limit_ext;
    assign at_limit  = sum >= limit_ext;

    always_comb
    begin
        phase_next     = phase_reg;
        state_next     = state_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        size_half_next = size_half_reg;
        size_low_next  = size_low_reg;
        line_idx_next  = line_idx_reg;
        pos_next       = pos_reg;
        cur_len_next   = cur_len_reg;
        pending_next   = pending_reg;
        emitted_next   = emitted_reg;
        seek_idx_next  = seek_idx_reg;
        seek_run_next  = seek_run_reg;
        cmd_next       = cmd_reg;
        push           = 1'b0;
        push_cmd       = cmd_reg;
        mem_we         = 1'b0;
        mem_waddr      = line_idx_cur[LINE_AW-1:0];
        mem_wdata      = {{(LINE_LEN_W-BYTE_W){1'b0}}, in_ch.in_byte};
        mem_re         = 1'b0;
        mem_raddr      = seek_idx_reg[LINE_AW-1:0];
        step_cmd       = '{value: in_ch.in_byte, npix: '0, err: 1'b0, done: 1'b0,
                           base: emitted_cur};
        start_seek     = 1'b0;
        seek_run       = 1'b0;
        seek_start     = line_idx_cur + LINE_CW'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    phase_next     = ph_cur;
                    hdr_cnt_next   = hdr_cur;
                    size_half_next = size_half_cur;
                    line_idx_next  = line_idx_cur;
                    pos_next       = pos_cur;
                    pending_next   = pending_cur;
                    emitted_next   = emitted_cur;

                    case (ph_cur)
                        PH_HEADER:
                        begin
                            hdr_cnt_next = hdr_cur + HDR_CNT_W'(1);
                            if (hdr_cur == HDR_CNT_W'(HEADER_BYTES - 1))
                            begin
                                hdr_cnt_next   = '0;
                                line_idx_next  = '0;
                                size_half_next = 1'b0;
                                phase_next     = PH_SIZES;
                                if (lines_total == '0)
                                begin
                                    phase_next    = PH_DONE;
                                    step_cmd.done = 1'b1;
                                end
                            end
                        end
                        PH_SIZES:
                        begin
                            if (cfg.big_line_sizes && !size_half_cur)
                            begin
                                size_low_next  = in_ch.in_byte;
                                size_half_next = 1'b1;
                            end
                            else
                            begin
                                mem_we = 32'(line_idx_cur) < 32'(MAX_LINES);
                                if (cfg.big_line_sizes)
                                    mem_wdata = {in_ch.in_byte, size_low_reg};
                                size_half_next = 1'b0;
                                line_idx_next  = line_idx_cur + LINE_CW'(1);
                                if ((line_idx_cur + LINE_CW'(1)) >= lines_total)
                                begin
                                    line_idx_next = '0;
                                    pos_next      = '0;
                                    pending_next  = '0;
                                    phase_next    = PH_DATA;
                                    start_seek    = 1'b1;
                                    seek_start    = '0;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            pending_next = '0;
                            pos_next     = pos_cur + LINE_LEN_W'(1);
                            if ((pending_cur != '0) && over)
                            begin
                                pos_next     = pos_cur;
                                phase_next   = PH_ERROR;
                                step_cmd.err = 1'b1;
                            end
                            else
                            begin
                                step_cmd.npix = NPIX_W'(pending_cur);
                                emitted_next  = sum[COUNT_W-1:0];
                                if (lb && is_run && (run_len != '0))
                                begin
                                    pending_next = run_len;
                                    start_seek   = line_end;
                                    seek_run     = 1'b1;
                                end
                                else if (lb && !is_run)
                                begin
                                    if (at_limit)
                                    begin
                                        phase_next   = PH_ERROR;
                                        step_cmd.err = 1'b1;
                                    end
                                    else
                                    begin
                                        step_cmd.npix = NPIX_W'(pending_cur) + NPIX_W'(1);
                                        emitted_next  = sum_p1[COUNT_W-1:0];
                                        start_seek    = line_end;
                                    end
                                end
                                else
                                begin
                                    start_seek = line_end;
                                end
                            end
                        end
                        PH_TAIL:
                        begin
                            pending_next = '0;
                            if (over)
                            begin
                                phase_next   = PH_ERROR;
                                step_cmd.err = 1'b1;
                            end
                            else
                            begin
                                step_cmd.npix = NPIX_W'(pending_cur);
                                step_cmd.done = 1'b1;
                                emitted_next  = sum[COUNT_W-1:0];
                                phase_next    = PH_DONE;
                            end
                        end
                        PH_ERROR:
                        begin
                            step_cmd.err = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (start_seek)
                    begin
                        cmd_next      = step_cmd;
                        seek_idx_next = seek_start;
                        seek_run_next = seek_run;
                        state_next    = ST_SEEK_ADDR;
                    end
                    else
                    begin
                        push     = 1'b1;
                        push_cmd = step_cmd;
                    end
                end
            end
            ST_SEEK_ADDR:
            begin
                if (seek_idx_reg >= lines_total)
                begin
                    push          = 1'b1;
                    push_cmd      = cmd_reg;
                    push_cmd.done = !seek_run_reg;
                    phase_next    = seek_run_reg ? PH_TAIL : PH_DONE;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_SEEK_DATA;
                end
            end
            ST_SEEK_DATA:
            begin
                if (rd_data_reg != '0)
                begin
                    line_idx_next = seek_idx_reg;
                    cur_len_next  = rd_data_reg;
                    pos_next      = '0;
                    phase_next    = PH_DATA;
                    push          = 1'b1;
                    push_cmd      = cmd_reg;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    seek_idx_next = seek_idx_reg + LINE_CW'(1);
                    state_next    = ST_SEEK_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_len_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= line_len_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            state_reg     <= ST_IDLE;
            hdr_cnt_reg   <= '0;
            size_half_reg <= 1'b0;
            line_idx_reg  <= '0;
            pos_reg       <= '0;
            pending_reg   <= '0;
            emitted_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            state_reg     <= state_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            size_half_reg <= size_half_next;
            line_idx_reg  <= line_idx_next;
            pos_reg       <= pos_next;
            pending_reg   <= pending_next;
            emitted_reg   <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_low_reg <= size_low_next;
        cur_len_reg  <= cur_len_next;
        seek_idx_reg <= seek_idx_next;
        seek_run_reg <= seek_run_next;
        cmd_reg      <= cmd_next;
    end

endmodule

/* src/trld_cmd_queue.sv */
// ----------------------------------------------------------------------------
// trld_cmd_queue
// short command fifo between the parser and the pixel sequencer
// ----------------------------------------------------------------------------
module trld_cmd_queue #(
    parameter int DEPTH = trld_pkg::CMD_QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  trld_pkg::trld_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output trld_pkg::trld_cmd_t pop_cmd,
    output logic                empty
);
    import trld_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    trld_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/trld_back.sv */
// ----------------------------------------------------------------------------
// trld_back
// expands commands into result items, one per free cycle, with output register
// ----------------------------------------------------------------------------
module trld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  trld_pkg::trld_cmd_t pop_cmd,
    output logic                pop,
    trld_out_if.source          out_ch
);
    import trld_pkg::*;

    function automatic logic [NPIX_W-1:0] result_total(input trld_cmd_t c);
        logic status;
        status = c.err || (c.done && (c.npix == '0));
        return c.npix + NPIX_W'(status);
    endfunction

    logic               busy_reg, busy_next;
    trld_cmd_t          cmd_reg, cmd_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [NPIX_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               held_valid_reg, held_valid_next;
    trld_result_t       held_reg, held_next;
    logic               out_valid_reg, out_valid_next;
    trld_result_t       out_reg, out_next;

    logic               out_free, last, is_pix;
    logic [NPIX_W-1:0]  nres;
    trld_result_t       item;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign nres     = result_total(cmd_reg);
    assign is_pix   = idx_reg < cmd_reg.npix;

    always_comb
    begin
        busy_next       = busy_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_next        = out_reg;
        pop             = 1'b0;
        last            = idx_reg == (nres - NPIX_W'(1));
        item.pixel       = is_pix ? cmd_reg.value : '0;
        item.pixel_valid = is_pix;
        item.run_last    = 1'b0;
        item.done_res    = cmd_reg.done && last;
        item.error       = !is_pix && cmd_reg.err;
        item.out_count   = is_pix ? cnt_reg + COUNT_W'(1) : cnt_reg;

        if (!busy_reg)
        begin
            if (!queue_empty)
            begin
                pop       = 1'b1;
                cmd_next  = pop_cmd;
                cnt_next  = pop_cmd.base;
                idx_next  = '0;
                pos_next  = '0;
                busy_next = (result_total(pop_cmd) != '0) || held_valid_reg;
            end
        end
        else if (out_free)
        begin
            if (held_valid_reg)
            begin
                // carried result opens the step
                out_next          = held_reg;
                out_next.run_last = nres == '0;
                out_valid_next    = 1'b1;
                held_valid_next   = 1'b0;
                pos_next          = POS_W'(1);
                if (nres == '0)
                    busy_next = 1'b0;
            end
            else
            begin
                if (pos_reg == POS_W'(RESULTS_PER_STEP))
                begin
                    held_next       = item;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    out_next          = item;
                    out_next.run_last = last || (pos_reg == POS_W'(RESULTS_PER_STEP - 1));
                    out_valid_next    = 1'b1;
                    pos_next          = pos_reg + POS_W'(1);
                end
                idx_next = idx_reg + NPIX_W'(1);
                if (is_pix)
                    cnt_next = cnt_reg + COUNT_W'(1);
                if (last)
                    busy_next = 1'b0;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel       = out_reg.pixel;
    assign out_ch.pixel_valid = out_reg.pixel_valid;
    assign out_ch.run_last    = out_reg.run_last;
    assign out_ch.done_res    = out_reg.done_res;
    assign out_ch.error       = out_reg.error;
    assign out_ch.out_count   = out_reg.out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cnt_reg  <= cnt_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

endmodule

/* src/texture_rle_line_decoder_core.sv */
// ----------------------------------------------------------------------------
// texture_rle_line_decoder_core
// line-oriented run-length texture decoder, byte in, pixel out
// ----------------------------------------------------------------------------
// The block takes a compressed texture one byte per transfer: a 4-byte size
// word, line_count line lengths (one byte each, or two bytes little-endian),
// then the coded lines, where a byte with its top three bits set repeats the
// next byte up to 31 times. Each input byte that yields any results yields
// them as a group closed by run_last; a group holds at most 31 results and a
// 32nd is carried to the next byte's group. Header, size and run-code bytes
// are taken one per cycle while the command queue is not full and no line
// search is running. Once the four-entry command queue is full, a byte waits
// while the pixel sequencer, which delivers one result per cycle while the
// output accepts, expands the earlier commands and loads each new command.
// A byte that ends a line, and the last size byte, hold the input while
// entries are read from the line-length memory and zero-length lines are
// skipped, until a line or the end is found. Line lengths are held in a
// single-port memory with a registered read and need no clearing after reset.
// The user must write registers only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module texture_rle_line_decoder_core #(
    parameter int MAX_LINES   = trld_pkg::MAX_LINES_DEF,
    parameter int QUEUE_DEPTH = trld_pkg::CMD_QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [trld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [trld_pkg::CFG_DATA_W-1:0]  cfg_data,
    trld_in_if.sink                          in_ch,
    trld_out_if.source                       out_ch
);
    import trld_pkg::*;

    logic [LINE_COUNT_W-1:0] line_count_reg, line_count_next;
    logic                    big_sizes_reg, big_sizes_next;
    logic [COUNT_W-1:0]      out_limit_reg, out_limit_next;

    trld_cfg_t cfg;
    logic      push, pop, queue_full, queue_empty;
    trld_cmd_t push_cmd, pop_cmd;

    always_comb
    begin
        line_count_next = line_count_reg;
        big_sizes_next  = big_sizes_reg;
        out_limit_next  = out_limit_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:     line_count_next = cfg_data[LINE_COUNT_W-1:0];
                CFG_BIG_LINE_SIZES: big_sizes_next  = cfg_data[0];
                CFG_OUT_LIMIT:      out_limit_next  = cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_COUNT_RST;
            big_sizes_reg  <= BIG_SIZES_RST;
            out_limit_reg  <= OUT_LIMIT_RST;
        end
        else
        begin
            line_count_reg <= line_count_next;
            big_sizes_reg  <= big_sizes_next;
            out_limit_reg  <= out_limit_next;
        end
    end

    assign cfg.line_count     = line_count_reg;
    assign cfg.big_line_sizes = big_sizes_reg;
    assign cfg.out_limit      = out_limit_reg;

    trld_front #(
        .MAX_LINES (MAX_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    trld_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    trld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule
